### design/fcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcd_pkg
// Shared constants, command codes, the row store request and a mask helper
// for the formal context derivation block.
// ----------------------------------------------------------------------------
package fcd_pkg;

    localparam int DEF_MAX_OBJECTS    = 64;
    localparam int DEF_MAX_ATTRIBUTES = 64;

    localparam int SET_W   = 64;
    localparam int IDX_W   = 6;
    localparam int COUNT_W = 7;

    localparam logic [2:0] CMD_WRITE_CELL  = 3'd0;
    localparam logic [2:0] CMD_READ_CELL   = 3'd1;
    localparam logic [2:0] CMD_ROW         = 3'd2;
    localparam logic [2:0] CMD_COLUMN      = 3'd3;
    localparam logic [2:0] CMD_DERIVE_ATTR = 3'd4;
    localparam logic [2:0] CMD_DERIVE_OBJ  = 3'd5;
    localparam logic [2:0] CMD_CLOSE_ATTR  = 3'd6;
    localparam logic [2:0] CMD_CLOSE_OBJ   = 3'd7;

    localparam logic CFG_NUM_OBJECTS    = 1'b0;
    localparam logic CFG_NUM_ATTRIBUTES = 1'b1;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [SET_W-1:0] wr_data;
    } mem_req_t;

    // Mask with the lowest n bits set; an n of 64 or more gives all ones.
    function automatic logic [SET_W-1:0] low_mask(input logic [COUNT_W-1:0] n);
        logic [SET_W-1:0] m;
        if (n >= COUNT_W'(SET_W)) begin
            m = '1;
        end
        else begin
            m = (SET_W'(1) << n[IDX_W-1:0]) - SET_W'(1);
        end
        return m;
    endfunction

endpackage

### design/fcd_row_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcd_row_store
// Relation memory, one row per object, with a registered synchronous read.
// Per-row valid bits cleared at reset make never-written rows read as zero.
// ----------------------------------------------------------------------------
module fcd_row_store #(
    parameter int MAX_OBJECTS    = fcd_pkg::DEF_MAX_OBJECTS,
    parameter int MAX_ATTRIBUTES = fcd_pkg::DEF_MAX_ATTRIBUTES
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  fcd_pkg::mem_req_t        req,
    output logic [fcd_pkg::SET_W-1:0] rd_data
);

    localparam int AW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;

    logic [MAX_ATTRIBUTES-1:0] mem [MAX_OBJECTS];
    logic [MAX_ATTRIBUTES-1:0] rd_data_reg;
    logic [MAX_OBJECTS-1:0]    row_valid_reg;
    logic                      rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr[AW-1:0]] <= req.wr_data[MAX_ATTRIBUTES-1:0];
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                row_valid_reg[req.wr_addr[AW-1:0]] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= row_valid_reg[req.rd_addr[AW-1:0]];
            end
        end
    end

    assign rd_data = rd_valid_reg ? fcd_pkg::SET_W'(rd_data_reg) : '0;

endmodule

### design/formal_context_derivation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// formal_context_derivation
// Object-by-attribute relation with cell access, rows, columns, derivation
// and closure of attribute and object sets.
// ----------------------------------------------------------------------------
// One item is processed at a time. Cell writes, cell reads and row reads read
// the addressed row and then load their result into the output register, and
// a command that fails its index check goes straight to the output register.
// Column reads and derivations scan the relation memory one row per cycle
// through its single read port; closures make two such scans. A result waits
// in the output register while the output is stalled, and a new item is taken
// in the cycle after the previous result enters that register.
module formal_context_derivation #(
    parameter int MAX_OBJECTS    = fcd_pkg::DEF_MAX_OBJECTS,
    parameter int MAX_ATTRIBUTES = fcd_pkg::DEF_MAX_ATTRIBUTES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [6:0]                   cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [2:0]                   cmd,
    input  logic [5:0]                   obj_index,
    input  logic [5:0]                   attr_index,
    input  logic                         bit_value,
    input  logic [63:0]                  query_set,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [63:0]                  result_set,
    output logic                         result_bit,
    output logic                         index_error
);

    localparam int SW = fcd_pkg::SET_W;
    localparam int CW = fcd_pkg::COUNT_W;
    localparam int IW = fcd_pkg::IDX_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ROW  = 5'b00010,
        S_SCAN = 5'b00100,
        S_DONE = 5'b01000,
        S_SPARE = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        PASS_ATTR = 2'd0,
        PASS_OBJ  = 2'd1,
        PASS_COL  = 2'd2
    } pass_t;

    state_t            state_reg, state_next;
    pass_t             pass_reg, pass_next;
    logic              second_reg, second_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              proc_valid_reg, proc_valid_next;
    logic [IW-1:0]     proc_idx_reg, proc_idx_next;
    logic [SW-1:0]     acc_reg, acc_next;
    logic [SW-1:0]     q_reg, q_next;
    logic              bit_reg, bit_next;
    logic              err_reg, err_next;
    logic [2:0]        cmd_reg, cmd_next;
    logic [IW-1:0]     ai_reg, ai_next;
    logic [IW-1:0]     oi_reg, oi_next;
    logic              val_reg, val_next;
    logic [CW-1:0]     num_objects_reg, num_objects_next;
    logic [CW-1:0]     num_attributes_reg, num_attributes_next;
    logic              out_valid_reg, out_valid_next;
    logic [SW-1:0]     result_set_reg, result_set_next;
    logic              result_bit_reg, result_bit_next;
    logic              index_error_reg, index_error_next;

    fcd_pkg::mem_req_t req;
    logic [SW-1:0]     rd_data;
    logic [CW-1:0]     obj_cnt;
    logic [CW-1:0]     attr_cnt;
    logic [SW-1:0]     attr_mask;
    logic [SW-1:0]     obj_mask;
    logic              obj_ok;
    logic              attr_ok;
    logic              out_load;
    logic [SW-1:0]     cell_mask;

    fcd_row_store #(
        .MAX_OBJECTS    (MAX_OBJECTS),
        .MAX_ATTRIBUTES (MAX_ATTRIBUTES)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_data (rd_data)
    );

    assign obj_cnt   = (num_objects_reg > CW'(MAX_OBJECTS)) ? CW'(MAX_OBJECTS)
                                                            : num_objects_reg;
    assign attr_cnt  = (num_attributes_reg > CW'(MAX_ATTRIBUTES)) ? CW'(MAX_ATTRIBUTES)
                                                                  : num_attributes_reg;
    assign attr_mask = fcd_pkg::low_mask(attr_cnt);
    assign obj_mask  = fcd_pkg::low_mask(obj_cnt);
    assign obj_ok    = {1'b0, obj_index} < obj_cnt;
    assign attr_ok   = {1'b0, attr_index} < attr_cnt;
    assign cell_mask = SW'(1) << ai_reg;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    assign cfg_ready   = 1'b1;
    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign result_set  = result_set_reg;
    assign result_bit  = result_bit_reg;
    assign index_error = index_error_reg;

    always_comb
    begin
        num_objects_next    = num_objects_reg;
        num_attributes_next = num_attributes_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fcd_pkg::CFG_NUM_OBJECTS:    num_objects_next    = cfg_data;
                fcd_pkg::CFG_NUM_ATTRIBUTES: num_attributes_next = cfg_data;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        pass_next       = pass_reg;
        second_next     = second_reg;
        cnt_next        = cnt_reg;
        proc_valid_next = 1'b0;
        proc_idx_next   = proc_idx_reg;
        acc_next        = acc_reg;
        q_next          = q_reg;
        bit_next        = bit_reg;
        err_next        = err_reg;
        cmd_next        = cmd_reg;
        ai_next         = ai_reg;
        oi_next         = oi_reg;
        val_next        = val_reg;
        req             = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next    = cmd;
                    ai_next     = attr_index;
                    oi_next     = obj_index;
                    val_next    = bit_value;
                    acc_next    = '0;
                    bit_next    = 1'b0;
                    err_next    = 1'b0;
                    cnt_next    = '0;
                    second_next = 1'b0;
                    unique case (cmd)
                        fcd_pkg::CMD_WRITE_CELL, fcd_pkg::CMD_READ_CELL:
                        begin
                            if (obj_ok && attr_ok)
                            begin
                                req.rd_en   = 1'b1;
                                req.rd_addr = obj_index;
                                state_next  = S_ROW;
                            end
                            else
                            begin
                                err_next   = 1'b1;
                                state_next = S_DONE;
                            end
                        end
                        fcd_pkg::CMD_ROW:
                        begin
                            if (obj_ok)
                            begin
                                req.rd_en   = 1'b1;
                                req.rd_addr = obj_index;
                                state_next  = S_ROW;
                            end
                            else
                            begin
                                err_next   = 1'b1;
                                state_next = S_DONE;
                            end
                        end
                        fcd_pkg::CMD_COLUMN:
                        begin
                            if (attr_ok)
                            begin
                                pass_next  = PASS_COL;
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                err_next   = 1'b1;
                                state_next = S_DONE;
                            end
                        end
                        fcd_pkg::CMD_DERIVE_ATTR, fcd_pkg::CMD_CLOSE_ATTR:
                        begin
                            pass_next   = PASS_ATTR;
                            q_next      = query_set & attr_mask;
                            second_next = (cmd == fcd_pkg::CMD_CLOSE_ATTR);
                            state_next  = S_SCAN;
                        end
                        default:
                        begin
                            pass_next   = PASS_OBJ;
                            q_next      = query_set & obj_mask;
                            acc_next    = attr_mask;
                            second_next = (cmd == fcd_pkg::CMD_CLOSE_OBJ);
                            state_next  = S_SCAN;
                        end
                    endcase
                end
            end
            S_ROW:
            begin
                if (cmd_reg == fcd_pkg::CMD_WRITE_CELL)
                begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = oi_reg;
                    req.wr_data = val_reg ? (rd_data | cell_mask) : (rd_data & ~cell_mask);
                end
                else if (cmd_reg == fcd_pkg::CMD_READ_CELL)
                begin
                    bit_next = rd_data[ai_reg];
                end
                else
                begin
                    acc_next = rd_data & attr_mask;
                end
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                if (cnt_reg < obj_cnt)
                begin
                    req.rd_en       = 1'b1;
                    req.rd_addr     = cnt_reg[IW-1:0];
                    cnt_next        = cnt_reg + CW'(1);
                    proc_valid_next = 1'b1;
                    proc_idx_next   = cnt_reg[IW-1:0];
                end
                if (proc_valid_reg)
                begin
                    unique case (pass_reg)
                        PASS_ATTR:
                        begin
                            if ((q_reg & ~rd_data) == '0)
                            begin
                                acc_next[proc_idx_reg] = 1'b1;
                            end
                        end
                        PASS_OBJ:
                        begin
                            if (q_reg[proc_idx_reg])
                            begin
                                acc_next = acc_reg & rd_data;
                            end
                        end
                        default:
                        begin
                            acc_next[proc_idx_reg] = rd_data[ai_reg];
                        end
                    endcase
                end
                else if (cnt_reg >= obj_cnt)
                begin
                    if (second_reg)
                    begin
                        second_next = 1'b0;
                        cnt_next    = '0;
                        if (pass_reg == PASS_ATTR)
                        begin
                            pass_next = PASS_OBJ;
                            q_next    = acc_reg & obj_mask;
                            acc_next  = attr_mask;
                        end
                        else
                        begin
                            pass_next = PASS_ATTR;
                            q_next    = acc_reg & attr_mask;
                            acc_next  = '0;
                        end
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next   = out_valid_reg && out_stall;
        result_set_next  = result_set_reg;
        result_bit_next  = result_bit_reg;
        index_error_next = index_error_reg;
        if (out_load)
        begin
            out_valid_next   = 1'b1;
            result_set_next  = acc_reg;
            result_bit_next  = bit_reg;
            index_error_next = err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            pass_reg           <= PASS_ATTR;
            second_reg         <= 1'b0;
            cnt_reg            <= '0;
            proc_valid_reg     <= 1'b0;
            num_objects_reg    <= 7'd64;
            num_attributes_reg <= 7'd64;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            pass_reg           <= pass_next;
            second_reg         <= second_next;
            cnt_reg            <= cnt_next;
            proc_valid_reg     <= proc_valid_next;
            num_objects_reg    <= num_objects_next;
            num_attributes_reg <= num_attributes_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        proc_idx_reg    <= proc_idx_next;
        acc_reg         <= acc_next;
        q_reg           <= q_next;
        bit_reg         <= bit_next;
        err_reg         <= err_next;
        cmd_reg         <= cmd_next;
        ai_reg          <= ai_next;
        oi_reg          <= oi_next;
        val_reg         <= val_next;
        result_set_reg  <= result_set_next;
        result_bit_reg  <= result_bit_next;
        index_error_reg <= index_error_next;
    end

endmodule

### design/fcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcd_checker
// Port-level assertions for the formal context derivation block, bound to
// its top level.
// ----------------------------------------------------------------------------
module fcd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] result_set,
    input logic        result_bit,
    input logic        index_error
);

    // A result that is held back keeps its value until its transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_set)
            && $stable(result_bit) && $stable(index_error))
        else $error("stalled result changed");

    // Only one item is in work: an input transfer closes the input side.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while an item is in work");

    // A new result appears only while an item was in work.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without an item in work");

    // An error or a cell read that returns a set bit carries an empty set.
    a_empty_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (index_error || result_bit) |-> result_set == 64'd0)
        else $error("set not empty on error or cell read");

    // An index error never reports a cell value.
    a_err_bit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && index_error |-> !result_bit)
        else $error("cell value reported with an index error");

endmodule

bind formal_context_derivation fcd_checker u_fcd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_set  (result_set),
    .result_bit  (result_bit),
    .index_error (index_error)
);

### tb/formal_context_derivation_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// formal_context_derivation_test
// Self-checking testbench for the object-by-attribute relation block. A short
// table of commands and size changes comes first, some with their results
// written in; then about 1650 random commands across many table sizes, with
// every result compared against an internal model of the relation.
// ----------------------------------------------------------------------------
module formal_context_derivation_test;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [5:0]  obj;
        logic [5:0]  attr;
        logic        bitv;
        logic [63:0] query;
    } context_op_t;

    typedef struct packed {
        logic [63:0] mask;
        logic        cell_bit;
        logic        bad_index;
    } cell_result_t;

    typedef enum logic {STEP_OP, STEP_SIZE} step_kind_t;

    typedef struct packed {
        step_kind_t   kind;
        logic         sel;
        logic [6:0]   value;
        context_op_t  op;
        logic         typed;
        cell_result_t want;
    } plan_step_t;

    localparam logic [63:0] ALL_ONES   = '1;
    localparam logic [63:0] ENDS_ONLY  = 64'h8000_0000_0000_0001;
    localparam logic [63:0] TOP_ONLY   = 64'h8000_0000_0000_0000;
    localparam int          PHASES     = 15;
    localparam int          PHASE_OPS  = 110;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [6:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  cmd;
    logic [5:0]  obj_index;
    logic [5:0]  attr_index;
    logic        bit_value;
    logic [63:0] query_set;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] result_set;
    logic        result_bit;
    logic        index_error;

    logic         typed_valid;
    cell_result_t typed_result;

    logic [63:0]  relation [64];
    logic [6:0]   obj_size;
    logic [6:0]   attr_size;
    cell_result_t pending [$];
    cell_result_t oldest;
    cell_result_t fresh;
    plan_step_t   plan [$];
    int           mismatches = 0;
    int           results_seen = 0;
    int           src_idle = 0;
    int           snk_idle = 0;

    formal_context_derivation dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < snk_idle);
    end

    function automatic int unsigned obj_span();
        return (obj_size > 7'd64) ? 64 : obj_size;
    endfunction

    function automatic int unsigned attr_span();
        return (attr_size > 7'd64) ? 64 : attr_size;
    endfunction

    function automatic logic [63:0] span_mask(input int unsigned n);
        return (n >= 64) ? ALL_ONES : ((64'd1 << n) - 64'd1);
    endfunction

    function automatic logic [63:0] objects_holding(input logic [63:0] attrs);
        logic [63:0] q;
        logic [63:0] res;
        q = attrs & span_mask(attr_span());
        res = '0;
        for (int i = 0; i < obj_span(); i++)
        begin
            if ((q & ~relation[i]) == 64'd0)
            begin
                res[i] = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic logic [63:0] attrs_shared(input logic [63:0] objs);
        logic [63:0] q;
        logic [63:0] res;
        q = objs & span_mask(obj_span());
        res = span_mask(attr_span());
        for (int i = 0; i < obj_span(); i++)
        begin
            if (q[i])
            begin
                res &= relation[i];
            end
        end
        return res;
    endfunction

    function automatic cell_result_t apply_op(input context_op_t op);
        cell_result_t r;
        logic         obj_ok;
        logic         attr_ok;
        r = '0;
        obj_ok = op.obj < obj_span();
        attr_ok = op.attr < attr_span();
        case (op.cmd)
            fcd_pkg::CMD_WRITE_CELL:
            begin
                if (obj_ok && attr_ok)
                begin
                    relation[op.obj][op.attr] = op.bitv;
                end
                else
                begin
                    r.bad_index = 1'b1;
                end
            end
            fcd_pkg::CMD_READ_CELL:
            begin
                if (obj_ok && attr_ok)
                begin
                    r.cell_bit = relation[op.obj][op.attr];
                end
                else
                begin
                    r.bad_index = 1'b1;
                end
            end
            fcd_pkg::CMD_ROW:
            begin
                if (obj_ok)
                begin
                    r.mask = relation[op.obj] & span_mask(attr_span());
                end
                else
                begin
                    r.bad_index = 1'b1;
                end
            end
            fcd_pkg::CMD_COLUMN:
            begin
                if (attr_ok)
                begin
                    for (int i = 0; i < obj_span(); i++)
                    begin
                        r.mask[i] = relation[i][op.attr];
                    end
                end
                else
                begin
                    r.bad_index = 1'b1;
                end
            end
            fcd_pkg::CMD_DERIVE_ATTR: r.mask = objects_holding(op.query);
            fcd_pkg::CMD_DERIVE_OBJ:  r.mask = attrs_shared(op.query);
            fcd_pkg::CMD_CLOSE_ATTR:  r.mask = attrs_shared(objects_holding(op.query));
            default:                  r.mask = objects_holding(attrs_shared(op.query));
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] result %0d: %s is %h, expected %h",
                 $realtime, results_seen, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == fcd_pkg::CFG_NUM_OBJECTS)
                begin
                    obj_size = cfg_data;
                end
                else
                begin
                    attr_size = cfg_data;
                end
            end
            if (in_valid && !in_stall)
            begin
                fresh = apply_op('{cmd, obj_index, attr_index, bit_value, query_set});
                pending.push_back(typed_valid ? typed_result : fresh);
            end
            if (out_valid && !out_stall)
            begin
                if (pending.size() == 0)
                begin
                    report_mismatch("unrequested result_set", result_set, '0);
                end
                else
                begin
                    oldest = pending.pop_front();
                    if (result_set !== oldest.mask)
                    begin
                        report_mismatch("result_set", result_set, oldest.mask);
                    end
                    if (result_bit !== oldest.cell_bit)
                    begin
                        report_mismatch("result_bit", 64'(result_bit), 64'(oldest.cell_bit));
                    end
                    if (index_error !== oldest.bad_index)
                    begin
                        report_mismatch("index_error", 64'(index_error),
                                        64'(oldest.bad_index));
                    end
                end
                results_seen++;
            end
        end
    end

    function automatic logic [5:0] pick_index(input int unsigned span);
        if ($urandom_range(0, 99) < 85 && span > 0)
        begin
            return 6'($urandom_range(0, span - 1));
        end
        return 6'($urandom_range(0, 63));
    endfunction

    function automatic logic [63:0] pick_query();
        logic [63:0] q;
        logic [5:0]  col;
        q = '0;
        case ($urandom_range(0, 9))
            0: q = '0;
            1: q = ALL_ONES;
            2, 3: q = relation[pick_index(obj_span())];
            4, 5:
            begin
                q[$urandom_range(0, 63)] = 1'b1;
                q[$urandom_range(0, 7)] = 1'b1;
            end
            6:
            begin
                col = pick_index(attr_span());
                for (int i = 0; i < 64; i++)
                begin
                    q[i] = relation[i][col];
                end
            end
            default: q = {$urandom, $urandom};
        endcase
        return q;
    endfunction

    function automatic context_op_t random_op();
        context_op_t op;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            op.cmd = fcd_pkg::CMD_WRITE_CELL;
        end
        else if (pick < 48)
        begin
            op.cmd = fcd_pkg::CMD_READ_CELL;
        end
        else if (pick < 56)
        begin
            op.cmd = fcd_pkg::CMD_ROW;
        end
        else if (pick < 64)
        begin
            op.cmd = fcd_pkg::CMD_COLUMN;
        end
        else if (pick < 72)
        begin
            op.cmd = fcd_pkg::CMD_DERIVE_ATTR;
        end
        else if (pick < 80)
        begin
            op.cmd = fcd_pkg::CMD_DERIVE_OBJ;
        end
        else if (pick < 90)
        begin
            op.cmd = fcd_pkg::CMD_CLOSE_ATTR;
        end
        else
        begin
            op.cmd = fcd_pkg::CMD_CLOSE_OBJ;
        end
        op.obj = pick_index(obj_span());
        op.attr = pick_index(attr_span());
        op.bitv = ($urandom_range(0, 9) < 6);
        op.query = pick_query();
        return op;
    endfunction

    task automatic send_op(input context_op_t op, input logic typed,
                           input cell_result_t want);
        while ($urandom_range(0, 99) < src_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op.cmd;
        obj_index <= op.obj;
        attr_index <= op.attr;
        bit_value <= op.bitv;
        query_set <= op.query;
        typed_valid <= typed;
        typed_result <= want;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (pending.size() != 0);
        @(posedge clk);
    endtask

    task automatic write_size(input logic sel, input logic [6:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic add_op(input logic [2:0] c, input logic [5:0] o, input logic [5:0] a,
                          input logic b, input logic [63:0] q);
        plan.push_back('{STEP_OP, 1'b0, 7'd0, '{c, o, a, b, q}, 1'b0, '0});
    endtask

    task automatic add_check(input logic [2:0] c, input logic [5:0] o,
                             input logic [5:0] a, input logic b, input logic [63:0] q,
                             input logic [63:0] m, input logic want_bit, input logic bad);
        plan.push_back('{STEP_OP, 1'b0, 7'd0, '{c, o, a, b, q}, 1'b1,
                         '{m, want_bit, bad}});
    endtask

    task automatic add_size(input logic sel, input logic [6:0] value);
        plan.push_back('{STEP_SIZE, sel, value, '0, 1'b0, '0});
    endtask

    initial
    begin
        logic [6:0] objs;
        logic [6:0] attrs;
        int         sent;

        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = fcd_pkg::CFG_NUM_OBJECTS;
        cfg_data = '0;
        in_valid = 1'b0;
        cmd = fcd_pkg::CMD_WRITE_CELL;
        obj_index = '0;
        attr_index = '0;
        bit_value = 1'b0;
        query_set = '0;
        out_stall = 1'b0;
        typed_valid = 1'b0;
        typed_result = '0;
        obj_size = 7'd64;
        attr_size = 7'd64;
        for (int i = 0; i < 64; i++)
        begin
            relation[i] = '0;
        end
        sent = 0;

        add_check(fcd_pkg::CMD_READ_CELL, 6'd0, 6'd0, 1'b0, '0, '0, 1'b0, 1'b0);
        add_check(fcd_pkg::CMD_ROW, 6'd63, 6'd0, 1'b0, '0, '0, 1'b0, 1'b0);
        add_check(fcd_pkg::CMD_DERIVE_ATTR, 6'd0, 6'd0, 1'b0, '0, ALL_ONES, 1'b0, 1'b0);
        add_check(fcd_pkg::CMD_DERIVE_OBJ, 6'd0, 6'd0, 1'b0, '0, ALL_ONES, 1'b0, 1'b0);
        add_check(fcd_pkg::CMD_WRITE_CELL, 6'd63, 6'd63, 1'b1, '0, '0, 1'b0, 1'b0);
        add_check(fcd_pkg::CMD_WRITE_CELL, 6'd0, 6'd0, 1'b1, ALL_ONES, '0, 1'b0, 1'b0);
        add_check(fcd_pkg::CMD_WRITE_CELL, 6'd0, 6'd63, 1'b1, '0, '0, 1'b0, 1'b0);
        add_check(fcd_pkg::CMD_READ_CELL, 6'd63, 6'd63, 1'b0, '0, '0, 1'b1, 1'b0);
        add_check(fcd_pkg::CMD_ROW, 6'd0, 6'd0, 1'b0, '0, ENDS_ONLY, 1'b0, 1'b0);
        add_check(fcd_pkg::CMD_COLUMN, 6'd0, 6'd63, 1'b0, '0, ENDS_ONLY, 1'b0, 1'b0);
        add_op(fcd_pkg::CMD_COLUMN, 6'd0, 6'd0, 1'b0, '0);
        add_check(fcd_pkg::CMD_DERIVE_ATTR, 6'd0, 6'd0, 1'b0, ALL_ONES, '0, 1'b0, 1'b0);
        add_op(fcd_pkg::CMD_DERIVE_ATTR, 6'd0, 6'd0, 1'b0, TOP_ONLY);
        add_op(fcd_pkg::CMD_CLOSE_ATTR, 6'd0, 6'd0, 1'b0, 64'd1);
        add_op(fcd_pkg::CMD_CLOSE_OBJ, 6'd0, 6'd0, 1'b0, ENDS_ONLY);
        add_size(fcd_pkg::CFG_NUM_OBJECTS, 7'd5);
        add_size(fcd_pkg::CFG_NUM_ATTRIBUTES, 7'd3);
        add_check(fcd_pkg::CMD_WRITE_CELL, 6'd5, 6'd0, 1'b1, '0, '0, 1'b0, 1'b1);
        add_check(fcd_pkg::CMD_READ_CELL, 6'd0, 6'd3, 1'b0, '0, '0, 1'b0, 1'b1);
        add_check(fcd_pkg::CMD_ROW, 6'd5, 6'd0, 1'b0, '0, '0, 1'b0, 1'b1);
        add_check(fcd_pkg::CMD_COLUMN, 6'd0, 6'd3, 1'b0, '0, '0, 1'b0, 1'b1);
        add_op(fcd_pkg::CMD_WRITE_CELL, 6'd4, 6'd2, 1'b1, '0);
        add_op(fcd_pkg::CMD_COLUMN, 6'd0, 6'd0, 1'b0, '0);
        add_op(fcd_pkg::CMD_DERIVE_ATTR, 6'd0, 6'd0, 1'b0, ALL_ONES);
        add_size(fcd_pkg::CFG_NUM_OBJECTS, 7'd0);
        add_size(fcd_pkg::CFG_NUM_ATTRIBUTES, 7'd0);
        add_check(fcd_pkg::CMD_READ_CELL, 6'd0, 6'd0, 1'b0, '0, '0, 1'b0, 1'b1);
        add_check(fcd_pkg::CMD_DERIVE_ATTR, 6'd0, 6'd0, 1'b0, ALL_ONES, '0, 1'b0, 1'b0);
        add_check(fcd_pkg::CMD_DERIVE_OBJ, 6'd0, 6'd0, 1'b0, ALL_ONES, '0, 1'b0, 1'b0);
        add_size(fcd_pkg::CFG_NUM_OBJECTS, 7'd127);
        add_size(fcd_pkg::CFG_NUM_ATTRIBUTES, 7'd127);
        add_op(fcd_pkg::CMD_ROW, 6'd63, 6'd0, 1'b0, '0);
        add_op(fcd_pkg::CMD_CLOSE_ATTR, 6'd0, 6'd0, 1'b0, '0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        src_idle = 36;
        snk_idle = 71;
        foreach (plan[r])
        begin
            if (plan[r].kind == STEP_SIZE)
            begin
                write_size(plan[r].sel, plan[r].value);
            end
            else
            begin
                send_op(plan[r].op, plan[r].typed, plan[r].want);
            end
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: begin objs = 7'd64;  attrs = 7'd64;  end
                1: begin objs = 7'd1;   attrs = 7'd1;   end
                2: begin objs = 7'd127; attrs = 7'd127; end
                3: begin objs = 7'd64;  attrs = 7'd1;   end
                4: begin objs = 7'd1;   attrs = 7'd64;  end
                5: begin objs = 7'd0;   attrs = 7'd17;  end
                default:
                begin
                    objs = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                                       : 7'($urandom_range(1, 12));
                    attrs = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                        : 7'($urandom_range(0, 10));
                end
            endcase
            write_size(fcd_pkg::CFG_NUM_OBJECTS, objs);
            write_size(fcd_pkg::CFG_NUM_ATTRIBUTES, attrs);
            for (int k = 0; k < PHASE_OPS; k++)
            begin
                if (sent < PHASES * PHASE_OPS / 3)
                begin
                    src_idle = 36;
                    snk_idle = 71;
                end
                else if (sent < 2 * PHASES * PHASE_OPS / 3)
                begin
                    src_idle = 71;
                    snk_idle = 36;
                end
                else
                begin
                    src_idle = 0;
                    snk_idle = 0;
                end
                if ($urandom_range(0, 99) == 0)
                begin
                    wait_drained();
                end
                send_op(random_op(), 1'b0, '0);
                sent++;
            end
        end

        wait_drained();
        repeat (140) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("formal_context_derivation regression: pass");
        end
        else
        begin
            $display("formal_context_derivation regression: fail");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("formal_context_derivation regression: fail");
        $finish;
    end

endmodule

### sim.f
design/fcd_pkg.sv
design/fcd_row_store.sv
design/formal_context_derivation.sv
design/fcd_checker.sv
tb/formal_context_derivation_test.sv
